// ----- design/npf_pkg.sv -----
// Package for the nucleotide pattern finder: shared constants, types and
// the symbol decoder. Depends on nothing; every other design file imports it.
package npf_pkg;

   // Fixed widths of the register and result fields.
   localparam int WINDOW_W      = 32;
   localparam int LENGTH_W      = 5;
   localparam int SYMBOL_W      = 8;
   localparam int POSITION_OUT_W = 16;
   localparam int COUNT_W       = 16;
   localparam int CSR_INDEX_W   = 4;

   // Longest pattern the window can hold, and the cap actually applied.
   localparam int MAX_PATTERN   = 16;
   localparam int LENGTH_CAP    = (MAX_PATTERN < 16) ? ((MAX_PATTERN < 1) ? 1 : MAX_PATTERN)
                                                     : 16;

   localparam int MAX_SEQUENCE_DEFAULT = 65536;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN        = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = CSR_INDEX_W'(1);

   // ASCII codes of the valid nucleotides.
   localparam logic [SYMBOL_W-1:0] SYM_A = 8'h41;
   localparam logic [SYMBOL_W-1:0] SYM_C = 8'h43;
   localparam logic [SYMBOL_W-1:0] SYM_G = 8'h47;
   localparam logic [SYMBOL_W-1:0] SYM_T = 8'h54;

   // Two-bit nucleotide codes.
   localparam logic [1:0] NUC_A = 2'd0;
   localparam logic [1:0] NUC_C = 2'd1;
   localparam logic [1:0] NUC_G = 2'd2;
   localparam logic [1:0] NUC_T = 2'd3;

   typedef struct packed {
      logic [WINDOW_W-1:0] pattern;
      logic [LENGTH_W-1:0] length;   // already clamped to 1..LENGTH_CAP
   } cfg_type;

   typedef struct packed {
      logic                      match_found;
      logic [POSITION_OUT_W-1:0] match_start;
      logic [COUNT_W-1:0]        match_total;
      logic                      bad_symbol;
      logic                      sequence_done;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] code;
   } nucleotide_type;

   function automatic nucleotide_type decode_symbol(input logic [SYMBOL_W-1:0] sym);
      nucleotide_type n;
      n.valid = 1'b1;
      n.code  = NUC_A;
      unique case (sym)
         SYM_A:   n.code = NUC_A;
         SYM_C:   n.code = NUC_C;
         SYM_G:   n.code = NUC_G;
         SYM_T:   n.code = NUC_T;
         default: n.valid = 1'b0;
      endcase
      return n;
   endfunction

endpackage

// ----- design/npf_csr_regs.sv -----
// Configuration registers of the nucleotide pattern finder: pattern and
// pattern length, with the length clamped to the supported range. Uses npf_pkg.
module npf_csr_regs
   import npf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WINDOW_W-1:0]    csr_data,
   output cfg_type                cfg
);

   logic [WINDOW_W-1:0] pattern_ff, pattern_in;
   logic [LENGTH_W-1:0] length_ff, length_in;

   assign csr_ready = 1'b1;

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN:        pattern_in = csr_data;
            CSR_PATTERN_LENGTH: length_in  = csr_data[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= LENGTH_W'(1);
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
      end
   end

   // A length of zero acts as one; anything past the cap acts as the cap.
   always_comb begin
      cfg.pattern = pattern_ff;
      if (length_ff == '0) begin
         cfg.length = LENGTH_W'(1);
      end else if (length_ff > LENGTH_W'(LENGTH_CAP)) begin
         cfg.length = LENGTH_W'(LENGTH_CAP);
      end else begin
         cfg.length = length_ff;
      end
   end

endmodule

// ----- design/npf_match_core.sv -----
// Input register, sequence state, window compare and result register of the
// nucleotide pattern finder. Uses npf_pkg types and the symbol decoder.
module npf_match_core
   import npf_pkg::*;
#(
   parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SYMBOL_W-1:0] req_symbol,
   input  logic                req_end,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output result_type          rsp
);

   localparam int PW = $clog2(MAX_SEQUENCE + 1);
   localparam int CW = (PW + 1 > 17) ? PW + 1 : 17;

   logic                s1_valid_ff, s1_valid_in;
   logic [SYMBOL_W-1:0] s1_symbol_ff;
   logic                s1_end_ff;

   logic                out_valid_ff, out_valid_in;
   result_type          result_ff, result_in;

   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [PW-1:0]       earliest_ff, earliest_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic                advance;
   nucleotide_type      nuc;
   logic                take;
   logic                hit;
   logic [WINDOW_W-1:0] window_new;
   logic [5:0]          shift;
   logic [WINDOW_W-1:0] hi_mask;
   logic [WINDOW_W-1:0] pat_hi;
   logic [CW-1:0]       pos_next_x;
   logic [CW-1:0]       len_x;
   logic [CW-1:0]       start_x;
   logic [COUNT_W-1:0]  count_new;

   // The item in the input register moves on when the result register is
   // free or is being emptied in the same cycle.
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp       = result_ff;

   always_comb begin
      nuc        = decode_symbol(s1_symbol_ff);
      take       = nuc.valid && (pos_ff < PW'(MAX_SEQUENCE));
      window_new = {nuc.code, window_ff[WINDOW_W-1:2]};
      // The newest 2*length bits sit at the top of the window; align the
      // pattern to them.
      shift      = 6'(7'd32 - {1'b0, cfg.length, 1'b0});
      hi_mask    = {WINDOW_W{1'b1}} << shift;
      pat_hi     = cfg.pattern << shift;
      pos_next_x = CW'(pos_ff) + CW'(1);
      len_x      = CW'(cfg.length);
      start_x    = pos_next_x - len_x;
      hit        = take && (pos_next_x >= len_x) && (start_x >= CW'(earliest_ff))
                   && ((window_new & hi_mask) == pat_hi);

      count_new  = count_ff;
      if (hit && (count_ff != {COUNT_W{1'b1}})) begin
         count_new = count_ff + COUNT_W'(1);
      end

      window_in   = window_ff;
      pos_in      = pos_ff;
      earliest_in = earliest_ff;
      count_in    = count_new;
      if (take) begin
         window_in = window_new;
         pos_in    = PW'(pos_next_x);
      end
      if (hit) begin
         earliest_in = PW'(pos_next_x);
      end
      if (s1_end_ff) begin
         window_in   = '0;
         pos_in      = '0;
         earliest_in = '0;
         count_in    = '0;
      end

      result_in.match_found = hit;
      if (!hit) begin
         result_in.match_start = '0;
      end else if (start_x > CW'(16'hFFFF)) begin
         result_in.match_start = {POSITION_OUT_W{1'b1}};
      end else begin
         result_in.match_start = POSITION_OUT_W'(start_x);
      end
      result_in.match_total   = count_new;
      result_in.bad_symbol    = !nuc.valid;
      result_in.sequence_done = s1_end_ff;

      s1_valid_in  = (s1_valid_ff && !advance) || (req_valid && req_ready);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         window_ff    <= '0;
         pos_ff       <= '0;
         earliest_ff  <= '0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            window_ff   <= window_in;
            pos_ff      <= pos_in;
            earliest_ff <= earliest_in;
            count_ff    <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_symbol_ff <= req_symbol;
         s1_end_ff    <= req_end;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

endmodule

// ----- design/nucleotide_pattern_finder_unit.sv -----
// Top level of the nucleotide pattern finder: stream ports, configuration
// port and port packing. Uses npf_pkg, npf_csr_regs and npf_match_core.
//
// Usage:
//   req_* carries one ASCII character per transaction in req_tdata; req_tlast
//   marks the final character of a sequence. rsp_* returns one result per
//   character: match start and running match total in rsp_tdata, match and
//   bad-character flags in rsp_tuser, and rsp_tlast echoing the end of the
//   sequence. csr_* writes the pattern (index 0) and the pattern length
//   (index 1); csr_ready is always high. Write registers only while idle.
//   An accepted request passes the input register and then the result
//   register before rsp_tvalid, with a single compare of the 32-bit window
//   in between; one character is taken every cycle while rsp_tready is high.
//   When the receiver stalls, the result register holds and one more request
//   is taken into the input register; then req_tready drops until rsp_tready.
//   Reset sets pattern to 0, length to 1 and clears all sequence state; the
//   transaction with tlast set also clears the sequence state after its
//   result is formed.
module nucleotide_pattern_finder_unit
   import npf_pkg::*;
#(
   parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] symbol
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // [15:0] match_start, [31:16] match_total
   output logic [1:0]             rsp_tuser,   // [0] match_found, [1] bad_symbol
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WINDOW_W-1:0]    csr_data
);

   cfg_type    cfg;
   result_type rsp;

   npf_csr_regs u_csr_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   npf_match_core #(
      .MAX_SEQUENCE (MAX_SEQUENCE)
   ) u_match_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_symbol (req_tdata),
      .req_end    (req_tlast),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {rsp.match_total, rsp.match_start};
   assign rsp_tuser = {rsp.bad_symbol, rsp.match_found};
   assign rsp_tlast = rsp.sequence_done;

`ifndef SYNTHESIS
   // A match never ends on a character that was rejected.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("match reported on a bad symbol");

   // A reported match is always counted.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[31:16] != 16'd0))
      else $error("match reported with a zero total");

   // Without a match the start position reads as zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("start position set without a match");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for nucleotide_pattern_finder_unit. It predicts every result
// in a small scoreboard class, writes the registers and idles the stream ports at random.
// Depends on npf_pkg and the design files.
`timescale 1ns / 1ps

module tb_top;
   import npf_pkg::*;

   // Tracks the search state of the block and keeps the results still due.
   class pattern_match_tracker;
      logic [WINDOW_W-1:0] pattern_bits;
      logic [LENGTH_W-1:0] length_field;
      logic [WINDOW_W-1:0] window;
      logic [16:0]         position;
      logic [16:0]         earliest_start;
      logic [COUNT_W-1:0]  match_tally;
      result_type          awaited[$];
      int                  mismatch_count;

      function new();
         pattern_bits   = '0;
         length_field   = LENGTH_W'(1);
         mismatch_count = 0;
         clear_run();
      endfunction

      function void clear_run();
         window         = '0;
         position       = '0;
         earliest_start = '0;
         match_tally    = '0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [WINDOW_W-1:0] data);
         if (index == CSR_PATTERN) begin
            pattern_bits = data;
         end else if (index == CSR_PATTERN_LENGTH) begin
            length_field = data[LENGTH_W-1:0];
         end
      endfunction

      // Pattern length actually searched for: a zero is read as one, and
      // anything above sixteen as sixteen.
      function int unsigned span();
         if (length_field == 0) return 1;
         if (length_field > 16) return 16;
         return length_field;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      function void take_symbol(logic [SYMBOL_W-1:0] sym, logic last);
         logic [1:0]          code;
         bit                  known;
         int unsigned         len;
         logic [WINDOW_W-1:0] tail;
         logic [WINDOW_W-1:0] mask;
         logic [16:0]         first;
         result_type          want;
         known = 1'b1;
         code  = NUC_A;
         case (sym)
            SYM_A:   code = NUC_A;
            SYM_C:   code = NUC_C;
            SYM_G:   code = NUC_G;
            SYM_T:   code = NUC_T;
            default: known = 1'b0;
         endcase
         want = '0;
         // Invalid characters never enter the window, so matches may span them.
         if (known && position < 17'(MAX_SEQUENCE_DEFAULT)) begin
            len      = span();
            window   = {code, window[WINDOW_W-1:2]};
            position = position + 17'd1;
            tail     = window >> (WINDOW_W - 2 * len);
            mask     = (len == 16) ? '1 : ((32'd1 << (2 * len)) - 32'd1);
            if (position >= 17'(len)) begin
               first = position - 17'(len);
               if (first >= earliest_start && tail == (pattern_bits & mask)) begin
                  want.match_found = 1'b1;
                  want.match_start = (first > 17'hFFFF) ? 16'hFFFF : first[15:0];
                  earliest_start   = position;
                  if (match_tally != 16'hFFFF) match_tally = match_tally + 16'd1;
               end
            end
         end
         want.match_total   = match_tally;
         want.bad_symbol    = !known;
         want.sequence_done = last;
         awaited = {awaited, want};
         if (last) clear_run();
      endfunction

      task flag_mismatch(string msg);
         mismatch_count++;
         $display("%0t: %s", $time, msg);
      endtask

      task compare_result(result_type got);
         result_type want;
         if (awaited.size() == 0) begin
            flag_mismatch($sformatf("result transaction with nothing pending (total %0d)",
                                    got.match_total));
            return;
         end
         want = awaited.pop_front();
         if (got.match_found !== want.match_found)
            flag_mismatch($sformatf("match_found %0b, expected %0b",
                                    got.match_found, want.match_found));
         if (got.match_start !== want.match_start)
            flag_mismatch($sformatf("match_start %0d, expected %0d",
                                    got.match_start, want.match_start));
         if (got.match_total !== want.match_total)
            flag_mismatch($sformatf("match_total %0d, expected %0d",
                                    got.match_total, want.match_total));
         if (got.bad_symbol !== want.bad_symbol)
            flag_mismatch($sformatf("bad_symbol %0b, expected %0b",
                                    got.bad_symbol, want.bad_symbol));
         if (got.sequence_done !== want.sequence_done)
            flag_mismatch($sformatf("sequence_done %0b, expected %0b",
                                    got.sequence_done, want.sequence_done));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [7:0] symbol
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [31:0]            rsp_tdata;   // [15:0] match_start, [31:16] match_total
   logic [1:0]             rsp_tuser;   // [0] match_found, [1] bad_symbol
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WINDOW_W-1:0]    csr_data;

   pattern_match_tracker tracker;
   int req_wait_max = 11;
   int rsp_wait_max = 11;
   int symbols_sent = 0;

   nucleotide_pattern_finder_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int draw_wait(int ceiling);
      if (ceiling == 0 || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, ceiling);
   endfunction

   function automatic logic [7:0] nucleotide_char(logic [1:0] code);
      case (code)
         NUC_A:   return SYM_A;
         NUC_C:   return SYM_C;
         NUC_G:   return SYM_G;
         default: return SYM_T;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_symbol(input logic [7:0] sym, input logic last);
      int pause;
      pause = draw_wait(req_wait_max);
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      tracker.take_symbol(sym, last);
      @(negedge clock);
   endtask

   task automatic stream_char(input logic [7:0] sym);
      send_symbol(sym, $urandom_range(0, 39) == 0);
      symbols_sent++;
   endtask

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] index, input logic [WINDOW_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(index, data);
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [31:0] pat, input logic [31:0] len_word,
                               input bit stray);
      put_reg(CSR_PATTERN, pat);
      put_reg(CSR_PATTERN_LENGTH, len_word);
      // Indexes past the register list must leave the configuration alone.
      if (stray) put_reg(CSR_INDEX_W'($urandom_range(2, 15)), $urandom);
      csr_valid <= 1'b0;
   endtask

   // Waits until every result due has arrived and the pipeline is empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly copies and partial copies of the pattern, some random nucleotides
   // and some arbitrary bytes; sequences end at random.
   task automatic run_phase(input int count);
      int          target;
      int          kind;
      int          k;
      int          reach;
      int unsigned len;
      logic [31:0] pat;
      target = symbols_sent + count;
      len    = tracker.span();
      pat    = tracker.pattern_bits;
      while (symbols_sent < target) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            for (k = 0; k < len; k++) begin
               if ($urandom_range(0, 24) == 0) stream_char(8'($urandom_range(0, 255)));
               stream_char(nucleotide_char(pat[2*k +: 2]));
            end
         end else if (kind < 7) begin
            reach = $urandom_range(1, len);
            for (k = 0; k < reach; k++) stream_char(nucleotide_char(pat[2*k +: 2]));
         end else if (kind < 9) begin
            reach = $urandom_range(1, 3);
            repeat (reach) stream_char(nucleotide_char(2'($urandom_range(0, 3))));
         end else begin
            stream_char(8'($urandom_range(0, 255)));
         end
      end
      settle();
   endtask

   initial begin
      int         pause;
      result_type seen;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         pause = draw_wait(rsp_wait_max);
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen.match_found   = rsp_tuser[0];
         seen.match_start   = rsp_tdata[15:0];
         seen.match_total   = rsp_tdata[31:16];
         seen.bad_symbol    = rsp_tuser[1];
         seen.sequence_done = rsp_tlast;
         tracker.compare_result(seen);
         @(negedge clock);
      end
   end

   initial begin
      int          phase;
      logic [31:0] pat;
      logic [31:0] len_word;
      tracker    = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset configuration searches for a single A; invalid bytes in between.
      send_symbol(SYM_A, 1'b0);
      send_symbol(SYM_C, 1'b0);
      send_symbol(SYM_A, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'h61, 1'b0);
      send_symbol(SYM_G, 1'b0);
      send_symbol(SYM_T, 1'b0);
      send_symbol(SYM_A, 1'b1);
      settle();

      // Pattern AA: overlapping candidates are rejected, a bad byte is skipped,
      // and the sequence ends on an invalid character.
      program_regs({16{NUC_A}}, 32'd2, 1'b0);
      repeat (4) send_symbol(SYM_A, 1'b0);
      send_symbol(8'h58, 1'b0);
      send_symbol(SYM_A, 1'b0);
      send_symbol(SYM_A, 1'b0);
      send_symbol(8'h2A, 1'b1);
      settle();

      // Phases leave sequences open, so new settings also apply mid-sequence.
      for (phase = 0; phase < 12; phase++) begin
         case (phase % 3)
            0:       pat = $urandom;
            1:       pat = {8{4'($urandom_range(0, 15))}};
            default: pat = (phase % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF;
         endcase
         len_word = $urandom;
         case (phase)
            0:       len_word[4:0] = 5'd1;
            1:       len_word[4:0] = 5'd16;
            2:       len_word[4:0] = 5'd0;
            3:       len_word[4:0] = 5'd31;
            4:       len_word[4:0] = 5'd17;
            5:       len_word[4:0] = 5'd2;
            default: len_word[4:0] = 5'($urandom_range(1, 16));
         endcase
         case (phase % 4)
            0: begin req_wait_max = 11; rsp_wait_max = 11; end
            1: begin req_wait_max = 0;  rsp_wait_max = 0;  end
            2: begin req_wait_max = 0;  rsp_wait_max = 11; end
            default: begin req_wait_max = 11; rsp_wait_max = 0; end
         endcase
         program_regs(pat, len_word, phase % 2 == 1);
         run_phase(120);
      end

      // One A pattern: a sequence made of a single invalid character, a run
      // of matches back to back, then a short sequence under random stalls.
      pat      = $urandom;
      pat[1:0] = NUC_A;
      len_word      = $urandom;
      len_word[4:0] = 5'd1;
      program_regs(pat, len_word, 1'b1);
      req_wait_max = 0;
      rsp_wait_max = 0;
      send_symbol(8'h23, 1'b1);
      repeat (24) send_symbol(SYM_A, 1'b0);
      send_symbol(SYM_C, 1'b0);
      send_symbol(8'h3A, 1'b0);
      send_symbol(SYM_A, 1'b1);
      req_wait_max = 11;
      rsp_wait_max = 11;
      send_symbol(SYM_A, 1'b0);
      send_symbol(SYM_C, 1'b0);
      send_symbol(SYM_A, 1'b1);
      settle();

      if (tracker.mismatch_count == 0) begin
         $display("nucleotide_pattern_finder_unit regression: pass");
      end else begin
         $display("nucleotide_pattern_finder_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #1_500_000;
      $display("nucleotide_pattern_finder_unit regression: fail");
      $finish;
   end

endmodule
